// ===== src/triangle_face_normal_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the triangle face normal unit
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_UNIT_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TFN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that one condition implies another on the next edge.
`define TFN_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== src/tfn_pkg.sv =====
// ---------------------------------------------------------------------------
// tfn_pkg
// Shared types and constants of the triangle face normal unit.
// ---------------------------------------------------------------------------
`default_nettype none
package tfn_pkg;
   localparam int LAYERS_DEF        = 4;
   localparam int MAX_VERTICES_DEF  = 1024;
   localparam int MAX_TRIANGLES_DEF = 1024;
   localparam int FRAC_BITS_DEF     = 16;
   localparam int COORD_W = 24;
   localparam int SUM_W   = 48;
   localparam int NORM_W  = 18;
   localparam int IDX_W   = 10;

   typedef enum logic [1:0] {
      OP_ADD_VERTEX   = 2'd0,
      OP_ADD_TRIANGLE = 2'd1,
      OP_CLEAR        = 2'd2,
      OP_NONE         = 2'd3
   } opcode_type;

   // Request into the arithmetic unit
   typedef struct packed {
      logic                      start;
      logic signed [49:0]        cx;
      logic signed [49:0]        cy;
      logic signed [49:0]        cz;
   } norm_req_type;

   typedef struct packed {
      logic                      done;
      logic                      busy;
      logic                      degenerate;
      logic [NORM_W-1:0]         nx;
      logic [NORM_W-1:0]         ny;
      logic [NORM_W-1:0]         nz;
   } norm_rsp_type;
endpackage
`default_nettype wire

// ===== src/triangle_face_normal_unit.sv =====
// ---------------------------------------------------------------------------
// triangle_face_normal_unit
// Per-layer vertex store with triangle face normals and running sums.
// ---------------------------------------------------------------------------
// channel | dir | fields
// req     | in  | tdata: opcode, layer, coord x/y/z, corner a/b/c
// rsp     | out | tdata: entry_index, normal x/y/z, flags, total x/y/z
// A vertex, clear or rejected request passes T_RDA, T_FIN and T_OUT before its response.
// A triangle takes 3 memory reads, 6 cross-product multiplies, up to 19 shift steps,
// 3 squares, 32 root steps and 3 bit-serial divides; a zero cross product skips the shift,
// squares, root and divides.
// Hold the response until taken; the next request is taken in the cycle after that.
// Reset clears counts and sums; no store clearing pass. One request at a time.
`default_nettype none
module triangle_face_normal_unit #(
   parameter int LAYERS        = tfn_pkg::LAYERS_DEF,
   parameter int MAX_VERTICES  = tfn_pkg::MAX_VERTICES_DEF,
   parameter int MAX_TRIANGLES = tfn_pkg::MAX_TRIANGLES_DEF,
   parameter int FRAC_BITS     = tfn_pkg::FRAC_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // opcode[1:0] layer[3:2] x[27:4] y[51:28] z[75:52] a[85:76] b[95:86] c[105:96]
   input  wire logic [111:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // index[9:0] nx[27:10] ny[45:28] nz[63:46] degenerate[64] store_full[65]
   // bad_corner[66] total_x[114:67] total_y[162:115] total_z[210:163]
   output logic [215:0]       rsp_tdata
);
   import tfn_pkg::*;

   localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
   localparam int VW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int TW = $clog2(MAX_TRIANGLES + 1);
   localparam int AW = LW + VW;

   typedef enum logic [9:0] {
      T_IDLE  = 10'b0000000001,
      T_RDA   = 10'b0000000010,
      T_RDB   = 10'b0000000100,
      T_RDC   = 10'b0000001000,
      T_LAT   = 10'b0000010000,
      T_MUL   = 10'b0000100000,
      T_NORM  = 10'b0001000000,
      T_WAIT  = 10'b0010000000,
      T_FIN   = 10'b0100000000,
      T_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [3*COORD_W-1:0] mem [LAYERS*MAX_VERTICES];
   logic [3*COORD_W-1:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [CW-1:0] vcnt_ff [LAYERS];
   logic [TW-1:0] tcnt_ff [LAYERS];
   logic [SUM_W-1:0] sx_ff, sy_ff, sz_ff;
   logic [111:0] item_ff;
   logic signed [COORD_W-1:0] va_ff [3];
   logic signed [COORD_W-1:0] vb_ff [3];
   logic signed [COORD_W-1:0] vc_ff [3];
   logic signed [COORD_W:0] e1 [3];
   logic signed [COORD_W:0] e2 [3];
   logic signed [49:0] p_ff [6];
   logic [2:0] step_ff;
   logic [215:0] out_ff;
   logic [215:0] first_out;
   logic rsp_v_ff;
   norm_req_type nreq;
   norm_rsp_type nrsp;

   opcode_type op;
   logic [1:0] lay_raw;
   logic [LW-1:0] lay;
   logic lay_ok;
   logic [IDX_W-1:0] ca, cb, cc;
   assign op = opcode_type'(item_ff[1:0]);
   assign lay_raw = item_ff[3:2];
   assign lay = LW'(lay_raw);
   assign lay_ok = 32'(lay_raw) < LAYERS;
   assign ca = item_ff[85:76];
   assign cb = item_ff[95:86];
   assign cc = item_ff[105:96];

   logic tri_full, tri_bad, v_full;
   assign v_full = 32'(vcnt_ff[lay]) >= MAX_VERTICES;
   assign tri_full = 32'(tcnt_ff[lay]) >= MAX_TRIANGLES;
   assign tri_bad = (32'(ca) >= 32'(vcnt_ff[lay])) || (32'(cb) >= 32'(vcnt_ff[lay]))
                 || (32'(cc) >= 32'(vcnt_ff[lay]));

   always_comb begin
      unique case (state_ff)
         T_RDA:   rd_addr = AW'({lay, VW'(ca)});
         T_RDB:   rd_addr = AW'({lay, VW'(cb)});
         default: rd_addr = AW'({lay, VW'(cc)});
      endcase
   end

   assign wr_en = (state_ff == T_RDA) && lay_ok && op == OP_ADD_VERTEX && !v_full;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{lay, VW'(vcnt_ff[lay])}] <= item_ff[75:4];
      end
      rd_ff <= mem[rd_addr];
   end

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_edge
         assign e1[g] = (COORD_W+1)'(vb_ff[g]) - (COORD_W+1)'(va_ff[g]);
         assign e2[g] = (COORD_W+1)'(vc_ff[g]) - (COORD_W+1)'(va_ff[g]);
      end
   endgenerate

   logic signed [COORD_W:0] mx, my;
   always_comb begin
      case (step_ff)
         3'd0: begin mx = e1[1]; my = e2[2]; end
         3'd1: begin mx = e2[1]; my = e1[2]; end
         3'd2: begin mx = e1[2]; my = e2[0]; end
         3'd3: begin mx = e2[2]; my = e1[0]; end
         3'd4: begin mx = e1[0]; my = e2[1]; end
         default: begin mx = e2[0]; my = e1[1]; end
      endcase
   end

   assign nreq.start = (state_ff == T_NORM);
   assign nreq.cx = p_ff[0] - p_ff[1];
   assign nreq.cy = p_ff[2] - p_ff[3];
   assign nreq.cz = p_ff[4] - p_ff[5];

   tfn_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
      .clock(clock), .reset(reset), .req(nreq), .rsp(nrsp)
   );

   logic [SUM_W-1:0] add_x, add_y, add_z;
   assign add_x = SUM_W'(va_ff[0]) + SUM_W'(vb_ff[0]) + SUM_W'(vc_ff[0]);
   assign add_y = SUM_W'(va_ff[1]) + SUM_W'(vb_ff[1]) + SUM_W'(vc_ff[1]);
   assign add_z = SUM_W'(va_ff[2]) + SUM_W'(vb_ff[2]) + SUM_W'(vc_ff[2]);

   assign req_tready = (state_ff == T_IDLE) && !rsp_v_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE:  if (req_tvalid && req_tready) state_in = T_RDA;
         T_RDA: begin
            if (lay_ok && op == OP_ADD_TRIANGLE && !tri_full && !tri_bad)
               state_in = T_RDB;
            else
               state_in = T_FIN;
         end
         T_RDB:   state_in = T_RDC;
         T_RDC:   state_in = T_LAT;
         T_LAT:   state_in = T_MUL;
         T_MUL:   if (step_ff == 3'd5) state_in = T_NORM;
         T_NORM:  state_in = T_WAIT;
         T_WAIT:  if (nrsp.done) state_in = T_FIN;
         T_FIN:   state_in = T_OUT;
         T_OUT:   state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   always_comb begin
      first_out = '0;
      if (!lay_ok) begin
         first_out[65] = (op != OP_NONE);
      end else if (op == OP_ADD_VERTEX) begin
         first_out[65] = v_full;
         if (!v_full) first_out[9:0] = IDX_W'(vcnt_ff[lay]);
      end else if (op == OP_ADD_TRIANGLE) begin
         first_out[65] = tri_full;
         first_out[66] = tri_bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         rsp_v_ff <= 1'b0;
         sx_ff <= '0;
         sy_ff <= '0;
         sz_ff <= '0;
         for (int i = 0; i < LAYERS; i++) begin
            vcnt_ff[i] <= '0;
            tcnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_v_ff && rsp_tready) rsp_v_ff <= 1'b0;
         if (state_ff == T_OUT) rsp_v_ff <= 1'b1;
         if (wr_en) vcnt_ff[lay] <= vcnt_ff[lay] + CW'(1);
         if (state_ff == T_RDA && lay_ok && op == OP_CLEAR) begin
            vcnt_ff[lay] <= '0;
            tcnt_ff[lay] <= '0;
         end
         if (state_ff == T_WAIT && nrsp.done) begin
            tcnt_ff[lay] <= tcnt_ff[lay] + TW'(1);
            sx_ff <= sx_ff + add_x;
            sy_ff <= sy_ff + add_y;
            sz_ff <= sz_ff + add_z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == T_IDLE && req_tvalid && req_tready) item_ff <= req_tdata;
      if (state_ff == T_RDB) {va_ff[2], va_ff[1], va_ff[0]} <= rd_ff;
      if (state_ff == T_RDC) {vb_ff[2], vb_ff[1], vb_ff[0]} <= rd_ff;
      if (state_ff == T_LAT) begin
         {vc_ff[2], vc_ff[1], vc_ff[0]} <= rd_ff;
         step_ff <= '0;
      end
      if (state_ff == T_MUL) begin
         p_ff[step_ff] <= 50'(mx * my);
         step_ff <= step_ff + 3'd1;
      end
      if (state_ff == T_RDA) out_ff <= first_out;
      if (state_ff == T_WAIT && nrsp.done) begin
         out_ff[9:0] <= IDX_W'(tcnt_ff[lay]);
         out_ff[27:10] <= nrsp.nx;
         out_ff[45:28] <= nrsp.ny;
         out_ff[63:46] <= nrsp.nz;
         out_ff[64] <= nrsp.degenerate;
      end
      if (state_ff == T_FIN) begin
         out_ff[114:67] <= sx_ff;
         out_ff[162:115] <= sy_ff;
         out_ff[210:163] <= sz_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = out_ff;
   logic unused;
   assign unused = nrsp.busy ^ ^item_ff[111:106];

`include "triangle_face_normal_unit_macros.svh"
   `TFN_ASSERT(a_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
   `TFN_ASSERT(a_ready_idle, clock, reset, !(req_tready && state_ff != T_IDLE), "ready while busy")
   `TFN_ASSERT_NEXT(a_out_valid, clock, reset, state_ff == T_OUT, rsp_tvalid, "response lost")
endmodule
`default_nettype wire

// ===== src/tfn_norm.sv =====
// ---------------------------------------------------------------------------
// tfn_norm
// Normalizes a cross product: shift, sum of squares over a shared
// multiplier, bit-serial square root and bit-serial divides.
// ---------------------------------------------------------------------------
`default_nettype none
module tfn_norm #(
   parameter int FRAC_BITS = tfn_pkg::FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tfn_pkg::norm_req_type req,
   output tfn_pkg::norm_rsp_type      rsp
);
   import tfn_pkg::*;

   localparam int DW = 31 + FRAC_BITS + 1;
   localparam logic [16:0] NMAX = 17'h1FFFF;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SHIFT = 7'b0000010,
      S_SQ    = 7'b0000100,
      S_SQRT  = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_STORE = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [49:0]       m_ff [3];
   logic [49:0]       m_in [3];
   logic [2:0]        neg_ff, neg_in;
   logic [63:0]       acc_ff, acc_in;
   logic [63:0]       rem_ff, rem_in;
   logic [31:0]       root_ff, root_in;
   logic [1:0]        sel_ff, sel_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [DW-1:0]     num_ff, num_in;
   logic [DW-1:0]     quo_ff, quo_in;
   logic [33:0]       drem_ff, drem_in;
   logic [NORM_W-1:0] n_ff [3];
   logic [NORM_W-1:0] n_in [3];
   logic              deg_ff, deg_in;

   logic [30:0] mul_a;
   logic [61:0] mul_p;
   logic [33:0] dtrial;
   logic [NORM_W-1:0] field;
   logic [DW-1:0] qmag;

   assign mul_a = m_ff[sel_ff][30:0];
   assign mul_p = mul_a * mul_a;
   assign dtrial = {drem_ff[32:0], num_ff[DW-1]};
   assign qmag = quo_ff;

   always_comb begin
      logic [16:0] sat;
      sat = (qmag > DW'(NMAX)) ? NMAX : qmag[16:0];
      field = neg_ff[sel_ff] ? NORM_W'(-{1'b0, sat}) : NORM_W'({1'b0, sat});
   end

   always_comb begin
      logic [63:0] r2;
      logic [63:0] t;
      logic [1:0]  pair;
      state_in = state_ff;
      m_in = m_ff;
      neg_in = neg_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      sel_in = sel_ff;
      cnt_in = cnt_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      drem_in = drem_ff;
      n_in = n_ff;
      deg_in = deg_ff;
      r2 = '0;
      t = '0;
      pair = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               neg_in = {req.cz[49], req.cy[49], req.cx[49]};
               m_in[0] = req.cx[49] ? 50'(-req.cx) : 50'(req.cx);
               m_in[1] = req.cy[49] ? 50'(-req.cy) : 50'(req.cy);
               m_in[2] = req.cz[49] ? 50'(-req.cz) : 50'(req.cz);
               if (req.cx == '0 && req.cy == '0 && req.cz == '0) begin
                  deg_in = 1'b1;
                  neg_in = '0;
                  quo_in = DW'(1) << FRAC_BITS;
                  sel_in = '0;
                  state_in = S_STORE;
               end else begin
                  deg_in = 1'b0;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            // shift right until largest below 2^31
            if ((m_ff[0][49:31] | m_ff[1][49:31] | m_ff[2][49:31]) != '0) begin
               m_in[0] = m_ff[0] >> 1;
               m_in[1] = m_ff[1] >> 1;
               m_in[2] = m_ff[2] >> 1;
            end else begin
               acc_in = '0;
               sel_in = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            acc_in = acc_ff + 64'(mul_p);
            if (sel_ff == 2'd2) begin
               sel_in = '0;
               cnt_in = 6'd31;
               rem_in = '0;
               root_in = '0;
               state_in = S_SQRT;
            end else begin
               sel_in = sel_ff + 2'd1;
            end
         end
         S_SQRT: begin
            // one result bit per cycle, two radicand bits in
            pair = acc_ff[63:62];
            r2 = {rem_ff[61:0], pair};
            t = {30'd0, root_ff, 2'b01};
            acc_in = acc_ff << 2;
            if (r2 >= t) begin
               rem_in = r2 - t;
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in = r2;
               root_in = {root_ff[30:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               sel_in = '0;
               state_in = S_DIV;
               cnt_in = 6'(DW);
               num_in = (DW'(m_ff[0][30:0]) << FRAC_BITS)
                        + DW'(root_in[31:1]);
               drem_in = '0;
               quo_in = '0;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_DIV: begin
            if (cnt_ff == '0) begin
               state_in = S_STORE;
            end else begin
               if (dtrial >= {2'b00, root_ff}) begin
                  drem_in = dtrial - {2'b00, root_ff};
                  quo_in = {quo_ff[DW-2:0], 1'b1};
               end else begin
                  drem_in = dtrial;
                  quo_in = {quo_ff[DW-2:0], 1'b0};
               end
               num_in = num_ff << 1;
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_STORE: begin
            n_in[sel_ff] = field;
            if (deg_ff) begin
               n_in[0] = field;
               n_in[1] = field;
               n_in[2] = field;
               state_in = S_DONE;
            end else if (sel_ff == 2'd2) begin
               state_in = S_DONE;
            end else begin
               sel_in = sel_ff + 2'd1;
               num_in = (DW'(m_ff[sel_in][30:0]) << FRAC_BITS)
                        + DW'(root_ff[31:1]);
               drem_in = '0;
               quo_in = '0;
               cnt_in = 6'(DW);
               state_in = S_DIV;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      m_ff <= m_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      sel_ff <= sel_in;
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      drem_ff <= drem_in;
      n_ff <= n_in;
      deg_ff <= deg_in;
   end

   assign rsp.done = (state_ff == S_DONE);
   assign rsp.busy = (state_ff != S_IDLE);
   assign rsp.degenerate = deg_ff;
   assign rsp.nx = n_ff[0];
   assign rsp.ny = n_ff[1];
   assign rsp.nz = n_ff[2];

`include "triangle_face_normal_unit_macros.svh"
   `TFN_ASSERT(a_start_idle, clock, reset, !(req.start && state_ff != S_IDLE), "start while busy")
   `TFN_ASSERT_NEXT(a_done_idle, clock, reset, state_ff == S_DONE, state_ff == S_IDLE, "done stuck")
   `TFN_ASSERT(a_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
endmodule
`default_nettype wire
